// ----- rtl/multi_tap_keypad_decoder_assert.svh -----
// Assertion macros for the multi-tap keypad decoder.
// Included by the top level; the SYNTH build sees empty bodies.
`ifndef MULTI_TAP_KEYPAD_DECODER_ASSERT_SVH
`define MULTI_TAP_KEYPAD_DECODER_ASSERT_SVH

`ifndef SYNTH
// Same-cycle implication, checked out of reset
`define MTK_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("keypad decoder check failed");
// Next-cycle implication, checked out of reset
`define MTK_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("keypad decoder check failed");
`else
`define MTK_ASSERT_NOW(lbl, ante, cons)
`define MTK_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ----- rtl/mtk_pkg.sv -----
// Shared types, constants and the multi-tap character table.
// No dependencies; imported by every module of the keypad decoder.
package mtk_pkg;

    localparam int unsigned DEBOUNCE_W = 16;
    localparam int unsigned TIME_W     = 32;
    localparam int unsigned KEY_W      = 4;
    localparam int unsigned TAP_W      = 2;
    localparam int unsigned CHAR_W     = 7;

    localparam int unsigned S_TDATA_W  = 40;
    localparam int unsigned M_TDATA_W  = 16;
    localparam int unsigned APB_ADDR_W = 3;
    localparam int unsigned APB_DATA_W = 32;

    localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = 16'd100;

    // register index, taken from paddr[2]
    localparam logic REG_IDX_DEBOUNCE = 1'b0;

    // queue between front and back; depth is a power of two so pointers wrap
    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QUEUE_AW    = 1;

    localparam logic [TAP_W-1:0] TAP_FIRST     = 2'd0;
    localparam logic [TAP_W-1:0] TAP_AFTER_NEW = 2'd1;

    typedef struct packed {
        logic             valid;
        logic [KEY_W-1:0] key;
    } key_xfer_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    // [tap][key] -> ASCII
    localparam logic [CHAR_W-1:0] TAP_TABLE [4][16] = '{
        '{7'h31, 7'h32, 7'h33, 7'h2E, 7'h34, 7'h35, 7'h36, 7'h2B,
          7'h37, 7'h38, 7'h39, 7'h43, 7'h60, 7'h30, 7'h23, 7'h44},
        '{7'h61, 7'h64, 7'h67, 7'h2C, 7'h6A, 7'h6D, 7'h70, 7'h2D,
          7'h73, 7'h76, 7'h79, 7'h43, 7'h60, 7'h20, 7'h23, 7'h44},
        '{7'h62, 7'h65, 7'h68, 7'h21, 7'h6B, 7'h6E, 7'h71, 7'h2A,
          7'h74, 7'h77, 7'h7A, 7'h43, 7'h60, 7'h5F, 7'h23, 7'h44},
        '{7'h63, 7'h66, 7'h69, 7'h3F, 7'h6C, 7'h6F, 7'h72, 7'h2F,
          7'h75, 7'h78, 7'h24, 7'h43, 7'h60, 7'h3D, 7'h23, 7'h44}
    };

    function automatic logic [CHAR_W-1:0] tap_char(input logic [TAP_W-1:0] sel,
                                                   input logic [KEY_W-1:0] key);
        return TAP_TABLE[sel][key];
    endfunction

endpackage

// ----- rtl/mtk_front.sv -----
// Front end: accepts key events, applies the debounce check, queues presses.
// Depends on mtk_pkg.
module mtk_front
    import mtk_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // row[1:0], column[3:2], now_ms[35:4], zero pad
    input  logic [0:0]            s_tuser,   // column_found[0]
    input  logic [DEBOUNCE_W-1:0] debounce_ms,
    input  queue_status_t         q_stat,
    output key_xfer_t             push
);

    logic [TIME_W-1:0] last_event_time_reg;
    logic [TIME_W-1:0] last_event_time_next;
    logic [1:0]        row;
    logic [1:0]        column;
    logic [TIME_W-1:0] now_ms;
    logic [TIME_W-1:0] elapsed;
    logic              in_xfer;
    logic              debounced;

    // unpack the transfer
    assign row     = s_tdata[1:0];
    assign column  = s_tdata[3:2];
    assign now_ms  = s_tdata[TIME_W+3:4];

    assign s_tready = !q_stat.full;
    assign in_xfer  = s_tvalid && s_tready;

    // wrapping elapsed time against the debounce interval
    assign elapsed   = now_ms - last_event_time_reg;
    assign debounced = elapsed >= {{(TIME_W-DEBOUNCE_W){1'b0}}, debounce_ms};

    // only debounced presses with a column go to the back end
    assign push.valid = in_xfer && debounced && s_tuser[0];
    assign push.key   = {row, column};

    // every event restamps the time, dropped or not
    assign last_event_time_next = in_xfer ? now_ms : last_event_time_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_event_time_reg <= '0;
        end else begin
            last_event_time_reg <= last_event_time_next;
        end
    end

endmodule

// ----- rtl/mtk_queue.sv -----
// Small key queue decoupling the front end from the back end.
// Depends on mtk_pkg.
module mtk_queue
    import mtk_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  key_xfer_t        push,
    input  logic             pop,
    output queue_status_t    q_stat,
    output logic [KEY_W-1:0] head_key
);

    logic [KEY_W-1:0]    entry_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wptr_reg;
    logic [QUEUE_AW-1:0] wptr_next;
    logic [QUEUE_AW-1:0] rptr_reg;
    logic [QUEUE_AW-1:0] rptr_next;
    logic [QUEUE_AW:0]   count_reg;
    logic [QUEUE_AW:0]   count_next;
    logic                do_push;
    logic                do_pop;

    assign q_stat.full  = count_reg == (QUEUE_AW+1)'(QUEUE_DEPTH);
    assign q_stat.empty = count_reg == '0;
    assign head_key     = entry_reg[rptr_reg];

    assign do_push = push.valid && !q_stat.full;
    assign do_pop  = pop && !q_stat.empty;

    // pointer and occupancy update
    always_comb begin
        wptr_next  = do_push ? wptr_reg + 1'b1 : wptr_reg;
        rptr_next  = do_pop  ? rptr_reg + 1'b1 : rptr_reg;
        count_next = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end else begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    // payload storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wptr_reg] <= push.key;
        end
    end

endmodule

// ----- rtl/mtk_back.sv -----
// Back end: tracks last key and tap count, looks up the character, output register.
// Depends on mtk_pkg.
module mtk_back
    import mtk_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  queue_status_t        q_stat,
    input  logic [KEY_W-1:0]     head_key,
    output logic                 pop,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata    // char_code[6:0], tap_index[8:7], zero pad
);

    logic [KEY_W-1:0]  last_key_reg;
    logic [KEY_W-1:0]  last_key_next;
    logic [TAP_W-1:0]  tap_count_reg;
    logic [TAP_W-1:0]  tap_count_next;
    logic              m_valid_reg;
    logic              m_valid_next;
    logic [CHAR_W-1:0] char_reg;
    logic [CHAR_W-1:0] char_next;
    logic [TAP_W-1:0]  tap_reg;
    logic [TAP_W-1:0]  tap_next;
    logic              same_key;
    logic [TAP_W-1:0]  sel;

    // take a key whenever the output slot is free or being drained
    assign pop      = !q_stat.empty && (!m_valid_reg || m_tready);
    assign same_key = head_key == last_key_reg;
    assign sel      = same_key ? tap_count_reg : TAP_FIRST;

    // tap state and result selection
    always_comb begin
        last_key_next  = last_key_reg;
        tap_count_next = tap_count_reg;
        char_next      = char_reg;
        tap_next       = tap_reg;
        m_valid_next   = m_tready ? 1'b0 : m_valid_reg;
        if (pop) begin
            last_key_next  = head_key;
            tap_count_next = same_key ? tap_count_reg + 1'b1 : TAP_AFTER_NEW;
            char_next      = tap_char(sel, head_key);
            tap_next       = sel;
            m_valid_next   = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_key_reg  <= '0;
            tap_count_reg <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            last_key_reg  <= last_key_next;
            tap_count_reg <= tap_count_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        char_reg <= char_next;
        tap_reg  <= tap_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(M_TDATA_W-CHAR_W-TAP_W){1'b0}}, tap_reg, char_reg};

endmodule

// ----- rtl/multi_tap_keypad_decoder.sv -----
// Multi-tap keypad decoder: takes one key event per clock (s_tvalid/s_tready), with no
// stalls while the result side keeps up. A press that passes the debounce check and has
// a column is queued by the front end in the accepting cycle; the back end resolves the
// tap count and table lookup as it pops the key from the queue and registers the character
// that m_tvalid then presents. Dropped and column-less events give no transfer. While
// a result is stalled on m_tready, the two-entry key queue holds two more presses before
// s_tready drops. debounce_ms sits at APB byte address 0 and resets to 100.
// Depends on mtk_pkg, mtk_front, mtk_queue, mtk_back and the assertion header.
`include "multi_tap_keypad_decoder_assert.svh"

module multi_tap_keypad_decoder
    import mtk_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // event stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // row[1:0], column[3:2], now_ms[35:4], zero pad
    input  logic [0:0]            s_tuser,   // column_found[0]
    // character stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // char_code[6:0], tap_index[8:7], zero pad
    // configuration
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    logic [DEBOUNCE_W-1:0] debounce_reg;
    logic [DEBOUNCE_W-1:0] debounce_next;
    logic                  cfg_wr;
    queue_status_t         q_stat;
    key_xfer_t             push;
    logic                  pop;
    logic [KEY_W-1:0]      head_key;

    // APB register file
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_IDX_DEBOUNCE);
    assign debounce_next = cfg_wr ? pwdata[DEBOUNCE_W-1:0] : debounce_reg;
    assign prdata = (paddr[2] == REG_IDX_DEBOUNCE)
                  ? {{(APB_DATA_W-DEBOUNCE_W){1'b0}}, debounce_reg} : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            debounce_reg <= DEBOUNCE_RESET;
        end else begin
            debounce_reg <= debounce_next;
        end
    end

    mtk_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .debounce_ms (debounce_reg),
        .q_stat      (q_stat),
        .push        (push)
    );

    mtk_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .pop      (pop),
        .q_stat   (q_stat),
        .head_key (head_key)
    );

    mtk_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_stat   (q_stat),
        .head_key (head_key),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // a full queue must hold off the event stream
    `MTK_ASSERT_NOW(a_full_stalls_input, q_stat.full, !s_tready)
    // a queued press leaves the queue non-empty on the next cycle
    `MTK_ASSERT_NEXT(a_push_lands, push.valid, !q_stat.empty)
    // a key taken by the back end shows up as a valid result
    `MTK_ASSERT_NEXT(a_pop_presents, pop, m_tvalid)

endmodule
